>>> rtl/tni_pkg.sv
// Shared types and constants for the three-nearest IDW interpolator.
package tni_pkg;

   localparam int COORD_W  = 24;
   localparam int VAL_W    = 32;
   localparam int IDX_W    = 10;
   localparam int NUM_W    = 11;
   localparam int SQ_W     = 2 * COORD_W + 1;
   localparam int DIST_W   = SQ_W + 1;
   localparam int PROD_W   = 2 * DIST_W;
   localparam int DEN_W    = PROD_W + 1;
   localparam int ACC_W    = PROD_W + VAL_W + 1;
   localparam int QUO_W    = VAL_W + 1;
   localparam int RAM_W    = VAL_W + 2 * COORD_W;
   localparam int STEP_W   = 6;
   localparam int DCNT_W   = 8;

   localparam logic [NUM_W-1:0]  NUM_NODES_RESET = NUM_W'(3);
   localparam logic [STEP_W-1:0] D_STEP_LAST     = STEP_W'(DIST_W - 1);
   localparam logic [STEP_W-1:0] V_STEP_LAST     = STEP_W'(VAL_W - 1);
   localparam logic [DCNT_W-1:0] DIV_STEPS       = DCNT_W'(ACC_W);

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef enum logic [2:0] {
      OP_P23,
      OP_P13,
      OP_P12,
      OP_V1,
      OP_V2,
      OP_V3,
      OP_END
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FETCH,
      ST_ARITH,
      ST_DIV,
      ST_ROUND,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load_node;
      logic start_scan;
      logic run_scan;
      logic start_fetch;
      logic run_fetch;
      logic start_arith;
      logic run_arith;
      logic start_div;
      logic run_div;
      logic do_round;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic fetch_done;
      logic exact_hit;
      logic arith_done;
      logic div_done;
      logic rsp_free;
   } status_type;

endpackage

>>> rtl/three_nearest_idw_interpolator.sv
// Top level of the three-nearest inverse-distance-squared interpolator.
// Load word: written into the node store, loads may follow back to back; no result.
// Query word: scan of n nodes (one store read per cycle), then value fetch, shift-add
// products and divide. An exact hit skips the arithmetic. A new word is taken once idle.
// Reset clears control and sets num_nodes to 3; node store holds garbage until loaded.
module three_nearest_idw_interpolator #(
   parameter int MAX_NODES = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_func,
   input  logic [tni_pkg::IDX_W-1:0]            req_node_index,
   input  logic signed [tni_pkg::COORD_W-1:0]   req_pos_x,
   input  logic signed [tni_pkg::COORD_W-1:0]   req_pos_y,
   input  logic signed [tni_pkg::VAL_W-1:0]     req_node_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [tni_pkg::VAL_W-1:0]     rsp_interp_value,
   output logic                                 rsp_exact_hit,
   output logic [tni_pkg::IDX_W-1:0]            rsp_nearest_index,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tni_pkg::NUM_W-1:0]            csr_wdata
);

   tni_pkg::cmd_type    cmd;
   tni_pkg::status_type status;

   assign csr_ready = 1'b1;

   tni_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   tni_dp #(
      .MAX_NODES (MAX_NODES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_node_index    (req_node_index),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_node_value    (req_node_value),
      .csr_valid         (csr_valid && csr_ready),
      .csr_wdata         (csr_wdata),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_interp_value  (rsp_interp_value),
      .rsp_exact_hit     (rsp_exact_hit),
      .rsp_nearest_index (rsp_nearest_index)
   );

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_func == tni_pkg::FUNC_QUERY) |=> req_stall)
      else $error("query word accepted but block not busy");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.load_rsp))
      else $error("result appeared without a finish command");

   a_rsp_no_clobber: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid || !rsp_stall))
      else $error("result overwritten while stalled");

endmodule

>>> rtl/tni_ram.sv
// Generic single-port-write, registered-read RAM.
module tni_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/tni_ctrl.sv
// Sequencer for node loads and query phases of the interpolator.
module tni_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_func,
   input  tni_pkg::status_type  status,
   output logic                 req_stall,
   output tni_pkg::cmd_type     cmd
);

   tni_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tni_pkg::ST_IDLE: begin
            if (req_valid && req_func == tni_pkg::FUNC_QUERY) begin
               state_in = tni_pkg::ST_SCAN;
            end
         end
         tni_pkg::ST_SCAN: begin
            if (status.scan_done) begin
               state_in = tni_pkg::ST_FETCH;
            end
         end
         tni_pkg::ST_FETCH: begin
            if (status.fetch_done) begin
               state_in = status.exact_hit ? tni_pkg::ST_FINISH : tni_pkg::ST_ARITH;
            end
         end
         tni_pkg::ST_ARITH: begin
            if (status.arith_done) begin
               state_in = tni_pkg::ST_DIV;
            end
         end
         tni_pkg::ST_DIV: begin
            if (status.div_done) begin
               state_in = tni_pkg::ST_ROUND;
            end
         end
         tni_pkg::ST_ROUND: begin
            state_in = tni_pkg::ST_FINISH;
         end
         tni_pkg::ST_FINISH: begin
            if (status.rsp_free) begin
               state_in = tni_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tni_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         tni_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_func == tni_pkg::FUNC_LOAD) begin
                  cmd.load_node = 1'b1;
               end else begin
                  cmd.start_scan = 1'b1;
               end
            end
         end
         tni_pkg::ST_SCAN: begin
            cmd.run_scan    = 1'b1;
            cmd.start_fetch = status.scan_done;
         end
         tni_pkg::ST_FETCH: begin
            cmd.run_fetch   = 1'b1;
            cmd.start_arith = status.fetch_done && !status.exact_hit;
         end
         tni_pkg::ST_ARITH: begin
            cmd.run_arith = 1'b1;
            cmd.start_div = status.arith_done;
         end
         tni_pkg::ST_DIV: begin
            cmd.run_div = 1'b1;
         end
         tni_pkg::ST_ROUND: begin
            cmd.do_round = 1'b1;
         end
         tni_pkg::ST_FINISH: begin
            cmd.load_rsp = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tni_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/tni_dp.sv
// Datapath: node store, distance scan, top-three keep, shift-add products, divider.
module tni_dp #(
   parameter int MAX_NODES = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tni_pkg::cmd_type                     cmd,
   output tni_pkg::status_type                  status,
   input  logic [tni_pkg::IDX_W-1:0]            req_node_index,
   input  logic signed [tni_pkg::COORD_W-1:0]   req_pos_x,
   input  logic signed [tni_pkg::COORD_W-1:0]   req_pos_y,
   input  logic signed [tni_pkg::VAL_W-1:0]     req_node_value,
   input  logic                                 csr_valid,
   input  logic [tni_pkg::NUM_W-1:0]            csr_wdata,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic signed [tni_pkg::VAL_W-1:0]     rsp_interp_value,
   output logic                                 rsp_exact_hit,
   output logic [tni_pkg::IDX_W-1:0]            rsp_nearest_index
);

   localparam int AW    = $clog2(MAX_NODES);
   localparam int CNTW  = $clog2(MAX_NODES + 1);
   localparam int CW    = tni_pkg::COORD_W;
   localparam int VW    = tni_pkg::VAL_W;
   localparam int DW    = tni_pkg::DIST_W;
   localparam int PW    = tni_pkg::PROD_W;
   localparam int NW    = tni_pkg::ACC_W;
   localparam int RW    = tni_pkg::DEN_W;
   localparam int QW    = tni_pkg::QUO_W;

   logic [tni_pkg::NUM_W-1:0]   num_nodes_ff, num_nodes_in;
   logic signed [CW-1:0]        qx_ff, qx_in, qy_ff, qy_in;
   logic [CNTW-1:0]             n_ff, n_in, addr_ff, addr_in;
   logic                        rdv_ff, rdv_in;
   logic [AW-1:0]               ridx_ff, ridx_in;
   logic [tni_pkg::SQ_W-1:0]    sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic                        s2v_ff, s2v_in;
   logic [AW-1:0]               s2idx_ff, s2idx_in;
   logic [DW-1:0]               bd_ff [3];
   logic [DW-1:0]               bd_in [3];
   logic [AW-1:0]               bi_ff [3];
   logic [AW-1:0]               bi_in [3];
   logic [1:0]                  fc_ff, fc_in, fidx_ff, fidx_in;
   logic                        fv_ff, fv_in;
   logic signed [VW-1:0]        val_ff [3];
   logic signed [VW-1:0]        val_in [3];
   tni_pkg::op_type             op_ff, op_in;
   logic                        ld_ff, ld_in;
   logic [tni_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [NW-1:0]               mcand_ff, mcand_in;
   logic [DW-1:0]               mplier_ff, mplier_in;
   logic                        msub_ff, msub_in;
   logic [NW-1:0]               acc_ff, acc_in;
   logic [PW-1:0]               p_ff [3];
   logic [PW-1:0]               p_in [3];
   logic [RW-1:0]               den_ff, den_in;
   logic [NW-1:0]               dvd_ff, dvd_in;
   logic [RW-1:0]               rem_ff, rem_in;
   logic [QW-1:0]               q_ff, q_in;
   logic                        neg_ff, neg_in;
   logic [tni_pkg::DCNT_W-1:0]  dcnt_ff, dcnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [VW-1:0]        rsp_value_ff, rsp_value_in;
   logic                        rsp_hit_ff, rsp_hit_in;
   logic [tni_pkg::IDX_W-1:0]   rsp_idx_ff, rsp_idx_in;

   logic                        wr_en;
   logic [AW-1:0]               rd_addr;
   logic [tni_pkg::RAM_W-1:0]   rd_data;
   logic                        scan_issue, fetch_issue, hit;
   logic signed [CW-1:0]        nx, ny;
   logic signed [CW:0]          dx, dy;
   logic signed [2*CW+1:0]      px, py;
   logic [DW-1:0]               node_dist;
   logic [AW-1:0]               bi_sel;
   logic signed [VW-1:0]        vsel;
   logic [VW-1:0]               vmag;
   logic [tni_pkg::STEP_W-1:0]  step_last;
   logic [NW-1:0]               addend;
   logic [RW:0]                 rem2, twice;
   logic                        ge;
   logic [QW-1:0]               q_signed;
   logic [31:0]                 sat_n;

   assign wr_en = cmd.load_node && (32'(req_node_index) < MAX_NODES);
   assign hit   = (bd_ff[0] == '0);

   always_comb begin
      case (fc_ff)
         2'd0:    bi_sel = bi_ff[0];
         2'd1:    bi_sel = bi_ff[1];
         default: bi_sel = bi_ff[2];
      endcase
   end

   assign scan_issue  = cmd.run_scan && (addr_ff < n_ff);
   assign fetch_issue = cmd.run_fetch && (fc_ff != 2'd3);
   assign rd_addr     = cmd.run_fetch ? bi_sel : addr_ff[AW-1:0];

   tni_ram #(
      .WIDTH (tni_pkg::RAM_W),
      .DEPTH (MAX_NODES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_node_index)),
      .wr_data ({req_node_value, req_pos_y, req_pos_x}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign nx   = rd_data[CW-1:0];
   assign ny   = rd_data[2*CW-1:CW];
   assign dx   = {qx_ff[CW-1], qx_ff} - {nx[CW-1], nx};
   assign dy   = {qy_ff[CW-1], qy_ff} - {ny[CW-1], ny};
   assign px   = dx * dx;
   assign py   = dy * dy;
   assign node_dist = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   always_comb begin
      case (op_ff)
         tni_pkg::OP_V1: vsel = val_ff[0];
         tni_pkg::OP_V2: vsel = val_ff[1];
         default:        vsel = val_ff[2];
      endcase
   end

   assign vmag      = vsel[VW-1] ? VW'(-vsel) : VW'(vsel);
   assign step_last = (op_ff == tni_pkg::OP_P23 || op_ff == tni_pkg::OP_P13 ||
                       op_ff == tni_pkg::OP_P12) ? tni_pkg::D_STEP_LAST
                                                 : tni_pkg::V_STEP_LAST;
   assign addend    = mplier_ff[0] ? (mcand_ff ^ {NW{msub_ff}}) : '0;

   assign rem2     = {rem_ff, dvd_ff[NW-1]};
   assign ge       = (rem2 >= {1'b0, den_ff});
   assign twice    = {rem_ff, 1'b0};
   assign q_signed = neg_ff ? (~q_ff + QW'(1)) : q_ff;

   always_comb begin
      if (num_nodes_ff < tni_pkg::NUM_W'(3)) begin
         sat_n = 32'd3;
      end else if (32'(num_nodes_ff) > MAX_NODES) begin
         sat_n = MAX_NODES;
      end else begin
         sat_n = 32'(num_nodes_ff);
      end
   end

   always_comb begin
      num_nodes_in = num_nodes_ff;
      qx_in = qx_ff;  qy_in = qy_ff;  n_in = n_ff;  addr_in = addr_ff;
      rdv_in = scan_issue;
      ridx_in = addr_ff[AW-1:0];
      sqx_in = px[tni_pkg::SQ_W-1:0];
      sqy_in = py[tni_pkg::SQ_W-1:0];
      s2v_in = rdv_ff;
      s2idx_in = ridx_ff;
      bd_in = bd_ff;  bi_in = bi_ff;
      fc_in = fc_ff;  fv_in = fetch_issue;  fidx_in = fc_ff;
      val_in = val_ff;
      op_in = op_ff;  ld_in = ld_ff;  step_in = step_ff;
      mcand_in = mcand_ff;  mplier_in = mplier_ff;  msub_in = msub_ff;
      acc_in = acc_ff;  p_in = p_ff;  den_in = den_ff;
      dvd_in = dvd_ff;  rem_in = rem_ff;  q_in = q_ff;  neg_in = neg_ff;
      dcnt_in = dcnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;  rsp_hit_in = rsp_hit_ff;  rsp_idx_in = rsp_idx_ff;

      if (csr_valid) begin
         num_nodes_in = csr_wdata;
      end

      if (scan_issue) begin
         addr_in = addr_ff + CNTW'(1);
      end
      if (cmd.run_scan && s2v_ff) begin
         if (node_dist < bd_ff[0]) begin
            bd_in[2] = bd_ff[1];   bi_in[2] = bi_ff[1];
            bd_in[1] = bd_ff[0];   bi_in[1] = bi_ff[0];
            bd_in[0] = node_dist;  bi_in[0] = s2idx_ff;
         end else if (node_dist < bd_ff[1]) begin
            bd_in[2] = bd_ff[1];   bi_in[2] = bi_ff[1];
            bd_in[1] = node_dist;  bi_in[1] = s2idx_ff;
         end else if (node_dist < bd_ff[2]) begin
            bd_in[2] = node_dist;  bi_in[2] = s2idx_ff;
         end
      end
      if (cmd.start_scan) begin
         qx_in   = req_pos_x;
         qy_in   = req_pos_y;
         n_in    = CNTW'(sat_n);
         addr_in = '0;
         rdv_in  = 1'b0;
         s2v_in  = 1'b0;
         for (int k = 0; k < 3; k++) begin
            bd_in[k] = '1;
         end
      end

      if (fetch_issue) begin
         fc_in = fc_ff + 2'd1;
      end
      for (int k = 0; k < 3; k++) begin
         if (fv_ff && fidx_ff == 2'(k)) begin
            val_in[k] = rd_data[tni_pkg::RAM_W-1:2*CW];
         end
      end
      if (cmd.start_fetch) begin
         fc_in = '0;
         fv_in = 1'b0;
      end

      if (cmd.run_arith) begin
         if (ld_ff) begin
            if (op_ff != tni_pkg::OP_END) begin
               ld_in   = 1'b0;
               step_in = '0;
            end
            case (op_ff)
               tni_pkg::OP_P23: begin
                  mcand_in = NW'(bd_ff[2]);  mplier_in = bd_ff[1];
                  msub_in = 1'b0;  acc_in = '0;
               end
               tni_pkg::OP_P13: begin
                  p_in[0] = acc_ff[PW-1:0];  den_in = den_ff + RW'(acc_ff[PW-1:0]);
                  mcand_in = NW'(bd_ff[2]);  mplier_in = bd_ff[0];
                  msub_in = 1'b0;  acc_in = '0;
               end
               tni_pkg::OP_P12: begin
                  p_in[1] = acc_ff[PW-1:0];  den_in = den_ff + RW'(acc_ff[PW-1:0]);
                  mcand_in = NW'(bd_ff[1]);  mplier_in = bd_ff[0];
                  msub_in = 1'b0;  acc_in = '0;
               end
               tni_pkg::OP_V1: begin
                  p_in[2] = acc_ff[PW-1:0];  den_in = den_ff + RW'(acc_ff[PW-1:0]);
                  mcand_in = NW'(p_ff[0]);  mplier_in = DW'(vmag);
                  msub_in = vsel[VW-1];  acc_in = '0;
               end
               tni_pkg::OP_V2: begin
                  mcand_in = NW'(p_ff[1]);  mplier_in = DW'(vmag);  msub_in = vsel[VW-1];
               end
               tni_pkg::OP_V3: begin
                  mcand_in = NW'(p_ff[2]);  mplier_in = DW'(vmag);  msub_in = vsel[VW-1];
               end
               default: begin
                  ld_in = 1'b1;
               end
            endcase
         end else begin
            acc_in    = acc_ff + addend + NW'(mplier_ff[0] && msub_ff);
            mcand_in  = {mcand_ff[NW-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[DW-1:1]};
            if (step_ff == step_last) begin
               ld_in = 1'b1;
               op_in = tni_pkg::op_type'(op_ff + 3'd1);
            end else begin
               step_in = step_ff + tni_pkg::STEP_W'(1);
            end
         end
      end
      if (cmd.start_arith) begin
         op_in  = tni_pkg::OP_P23;
         ld_in  = 1'b1;
         den_in = '0;
      end

      if (cmd.run_div && dcnt_ff != tni_pkg::DIV_STEPS) begin
         rem_in  = ge ? RW'(rem2 - {1'b0, den_ff}) : rem2[RW-1:0];
         dvd_in  = {dvd_ff[NW-2:0], 1'b0};
         q_in    = {q_ff[QW-2:0], ge};
         dcnt_in = dcnt_ff + tni_pkg::DCNT_W'(1);
      end
      if (cmd.start_div) begin
         neg_in  = acc_ff[NW-1];
         dvd_in  = acc_ff[NW-1] ? (~acc_ff + NW'(1)) : acc_ff;
         rem_in  = '0;
         q_in    = '0;
         dcnt_in = '0;
      end
      if (cmd.do_round && (twice >= {1'b0, den_ff})) begin
         q_in = q_ff + QW'(1);
      end

      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = hit;
         rsp_idx_in   = tni_pkg::IDX_W'(bi_ff[0]);
         rsp_value_in = hit ? val_ff[0] : q_signed[VW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_nodes_ff <= tni_pkg::NUM_NODES_RESET;
         rdv_ff       <= 1'b0;
         s2v_ff       <= 1'b0;
         fv_ff        <= 1'b0;
         ld_ff        <= 1'b0;
         op_ff        <= tni_pkg::OP_END;
         rsp_valid_ff <= 1'b0;
      end else begin
         num_nodes_ff <= num_nodes_in;
         rdv_ff       <= rdv_in;
         s2v_ff       <= s2v_in;
         fv_ff        <= fv_in;
         ld_ff        <= ld_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      qx_ff <= qx_in;  qy_ff <= qy_in;  n_ff <= n_in;  addr_ff <= addr_in;
      ridx_ff <= ridx_in;  sqx_ff <= sqx_in;  sqy_ff <= sqy_in;  s2idx_ff <= s2idx_in;
      bd_ff <= bd_in;  bi_ff <= bi_in;
      fc_ff <= fc_in;  fidx_ff <= fidx_in;  val_ff <= val_in;
      step_ff <= step_in;  mcand_ff <= mcand_in;  mplier_ff <= mplier_in;
      msub_ff <= msub_in;  acc_ff <= acc_in;  p_ff <= p_in;  den_ff <= den_in;
      dvd_ff <= dvd_in;  rem_ff <= rem_in;  q_ff <= q_in;  neg_ff <= neg_in;
      dcnt_ff <= dcnt_in;
      rsp_value_ff <= rsp_value_in;  rsp_hit_ff <= rsp_hit_in;  rsp_idx_ff <= rsp_idx_in;
   end

   assign status.scan_done  = (addr_ff == n_ff) && !rdv_ff && !s2v_ff;
   assign status.fetch_done = (fc_ff == 2'd3) && !fv_ff;
   assign status.exact_hit  = hit;
   assign status.arith_done = ld_ff && (op_ff == tni_pkg::OP_END);
   assign status.div_done   = (dcnt_ff == tni_pkg::DIV_STEPS);
   assign status.rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_interp_value  = rsp_value_ff;
   assign rsp_exact_hit     = rsp_hit_ff;
   assign rsp_nearest_index = rsp_idx_ff;

endmodule
